// File: rtl/csf_pkg.sv
package csf_pkg;

  // both lengths share this format, so it cancels in the ratio
  localparam int unsigned LENGTH_FRAC_BITS = 24;
  localparam int unsigned STRAIN_FRAC = 24;
  localparam int unsigned RATIO_W = 57;
  localparam int unsigned FORCE_W = 48;
  localparam logic [47:0] FORCE_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [31:0] LN2_Q31 = 32'd1488522236;

  localparam logic [2:0] REG_EXP_SCALE = 3'd0;
  localparam logic [2:0] REG_EXP_RATE = 3'd1;
  localparam logic [2:0] REG_RECRUIT = 3'd2;
  localparam logic [2:0] REG_MODULUS = 3'd3;
  localparam logic [2:0] REG_INTERCEPT = 3'd4;
  localparam logic [2:0] REG_THICKNESS = 3'd5;

  typedef enum logic [1:0] {
    REGION_SLACK = 2'd0,
    REGION_EXP = 2'd1,
    REGION_LINEAR = 2'd2
  } region_t;

  // partial quotient carried down the divider chain
  typedef struct packed {
    logic        valid;
    logic [56:0] rem;
    logic [56:0] num;
    logic [56:0] quo;
    logic        zero_div;
    logic [31:0] den;
    logic [31:0] stiffness;
  } div_stage_t;

  // 2^(k/depth) in q.30, built by integer taylor sums at elaboration
  function automatic logic [31:0] pow2_entry(input int unsigned k, input int unsigned depth);
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    z = (64'(k) * 64'(LN2_Q31)) / 64'(depth);
    sum = 64'd1 << 31;
    term = 64'd1 << 31;
    for (int i = 1; i <= 16; i++) begin
      term = ((term * z) >> 31) / 64'(i);
      sum = sum + term;
    end
    return 32'((sum + 64'd1) >> 1);
  endfunction

endpackage

// File: rtl/csf_div_cell.sv
module csf_div_cell
  import csf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  div_stage_t din,
  output div_stage_t dout
);

  // three quotient bits per cell, restoring
  localparam int unsigned BITS = 3;

  div_stage_t nxt;
  logic [57:0] r;

  always_comb begin
    nxt = din;
    r = {1'b0, din.rem};
    for (int i = 0; i < BITS; i++) begin
      r = {r[56:0], nxt.num[56]};
      nxt.num = {nxt.num[55:0], 1'b0};
      if (r >= {26'd0, din.den}) begin
        r = r - {26'd0, din.den};
        nxt.quo = {nxt.quo[55:0], 1'b1};
      end else begin
        nxt.quo = {nxt.quo[55:0], 1'b0};
      end
    end
    nxt.rem = r[56:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.rem <= nxt.rem;
      dout.num <= nxt.num;
      dout.quo <= nxt.quo;
      dout.zero_div <= din.zero_div;
      dout.den <= din.den;
      dout.stiffness <= din.stiffness;
    end
  end

endmodule

// File: rtl/csf_force_pipe.sv
module csf_force_pipe
  import csf_pkg::*;
#(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [56:0] ratio,
  input  logic [31:0] stiffness,
  input  logic [31:0] exp_scale,
  input  logic [23:0] exp_rate,
  input  logic [15:0] recruit_strain,
  input  logic [31:0] linear_modulus,
  input  logic [15:0] intercept_strain,
  input  logic [15:0] tissue_thickness,
  output logic        out_valid,
  output logic [47:0] force_res,
  output logic [1:0]  region,
  output logic        saturated
);

  localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH);

  function automatic logic [7:0] blen128(input logic [127:0] v);
    logic [7:0] n;
    n = 8'd0;
    for (int i = 0; i < 128; i++) begin
      if (v[i]) n = 8'(i + 1);
    end
    return n;
  endfunction

  // 2^(k/depth) in q.30
  logic [31:0] pow2_tab [EXP_TABLE_DEPTH+1];

  for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [31:0] ENTRY = pow2_entry(k, EXP_TABLE_DEPTH);
    assign pow2_tab[k] = ENTRY;
  end

  // stage 1: strain, region, coefficient
  logic        v1;
  logic [1:0]  reg1;
  logic [55:0] strain1;
  logic [47:0] c1;
  logic [31:0] bs1;

  // stage 2: exponent, partial coefficient products
  logic        v2;
  logic [1:0]  reg2;
  logic [55:0] d2;
  logic [32:0] y2;
  logic [63:0] sa_lo2, sm_lo2;
  logic [47:0] sa_hi2, sm_hi2;

  // stage 3: table read, coefficient products
  logic        v3;
  logic [1:0]  reg3;
  logic [55:0] d3;
  logic [7:0]  n3;
  logic [31:0] lo3, hi3;
  logic [23:0] rr3;
  logic [79:0] a1_3, p1_3;

  // stage 4: interpolation
  logic        v4;
  logic [1:0]  reg4;
  logic [55:0] d4;
  logic [7:0]  n4;
  logic [31:0] m4;
  logic [79:0] a1_4, p1_4;

  // stage 5: partial products of the wide terms
  logic        v5;
  logic [1:0]  reg5;
  logic [7:0]  n5;
  logic [79:0] a1_5;
  logic [63:0] ea0_5, ea1_5;
  logic [47:0] ea2_5;
  logic [63:0] lp00_5, lp10_5;
  logic [55:0] lp01_5, lp11_5;
  logic [47:0] lp20_5;
  logic [39:0] lp21_5;

  // stage 6: sums of the partial products
  logic         v6;
  logic [1:0]   reg6;
  logic [7:0]   n6;
  logic [79:0]  a1_6;
  logic [111:0] a6;
  logic [135:0] t_lin6;

  logic [55:0] rec24, icp24, strain_c;
  logic [47:0] rate_prod;
  logic [23:0] yfrac;
  logic [IDX_W+23:0] u;
  logic [IDX_W:0] idx;
  logic [23:0] rr;

  assign rec24 = {32'd0, recruit_strain, 8'd0};
  assign icp24 = {32'd0, intercept_strain, 8'd0};
  assign strain_c = ratio[55:0] - 56'(1 << STRAIN_FRAC);
  // exponential strain never exceeds 24 bits
  assign rate_prod = 48'(exp_rate) * 48'(strain_c[23:0]);

  assign yfrac = y2[23:0];
  assign u = (IDX_W+24)'(yfrac) << IDX_W;
  assign idx = {1'b0, u[IDX_W+23:24]};
  assign rr = u[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= 48'(stiffness) * 48'(tissue_thickness);
      if (ratio <= 57'(1 << STRAIN_FRAC)) begin
        reg1 <= REGION_SLACK;
        strain1 <= 56'd0;
      end else begin
        strain1 <= strain_c;
        reg1 <= (strain_c > rec24) ? REGION_LINEAR : REGION_EXP;
      end
      bs1 <= rate_prod[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reg2 <= reg1;
      d2 <= (strain1 > icp24) ? strain1 - icp24 : 56'd0;
      y2 <= 33'((64'(bs1) * 64'(LOG2E_Q30)) >> 30);
      sa_lo2 <= 64'(c1[31:0]) * 64'(exp_scale);
      sa_hi2 <= 48'(c1[47:32]) * 48'(exp_scale);
      sm_lo2 <= 64'(c1[31:0]) * 64'(linear_modulus);
      sm_hi2 <= 48'(c1[47:32]) * 48'(linear_modulus);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reg3 <= reg2;
      d3 <= d2;
      n3 <= y2[32] ? 8'hFF : y2[31:24];
      lo3 <= pow2_tab[idx];
      hi3 <= pow2_tab[idx + 1'b1];
      rr3 <= rr;
      a1_3 <= 80'(sa_lo2) + (80'(sa_hi2) << 32);
      p1_3 <= 80'(sm_lo2) + (80'(sm_hi2) << 32);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reg4 <= reg3;
      d4 <= d3;
      n4 <= n3;
      m4 <= lo3 + 32'((56'(hi3 - lo3) * 56'(rr3)) >> 24);
      a1_4 <= a1_3;
      p1_4 <= p1_3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reg5 <= reg4;
      n5 <= n4;
      a1_5 <= a1_4;
      ea0_5 <= 64'(a1_4[31:0]) * 64'(m4);
      ea1_5 <= 64'(a1_4[63:32]) * 64'(m4);
      ea2_5 <= 48'(a1_4[79:64]) * 48'(m4);
      lp00_5 <= 64'(p1_4[31:0]) * 64'(d4[31:0]);
      lp01_5 <= 56'(p1_4[31:0]) * 56'(d4[55:32]);
      lp10_5 <= 64'(p1_4[63:32]) * 64'(d4[31:0]);
      lp11_5 <= 56'(p1_4[63:32]) * 56'(d4[55:32]);
      lp20_5 <= 48'(p1_4[79:64]) * 48'(d4[31:0]);
      lp21_5 <= 40'(p1_4[79:64]) * 40'(d4[55:32]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reg6 <= reg5;
      n6 <= n5;
      a1_6 <= a1_5;
      a6 <= 112'(ea0_5) + (112'(ea1_5) << 32) + (112'(ea2_5) << 64);
      t_lin6 <= 136'(lp00_5) + (136'(lp01_5) << 32) + (136'(lp10_5) << 32)
              + (136'(lp11_5) << 64) + (136'(lp20_5) << 64) + (136'(lp21_5) << 96);
    end
  end

  logic         exp_big;
  logic [127:0] t_exp;
  logic [47:0]  force_next;
  logic         saturated_next;

  always_comb begin
    exp_big = (a6 != 112'd0) && ((9'(blen128(128'(a6))) + 9'(n6)) > 9'd119);
    t_exp = (128'(a6) << n6) - (128'(a1_6) << 30);
    force_next = 48'd0;
    saturated_next = 1'b0;
    unique case (reg6)
      REGION_LINEAR: begin
        if (t_lin6[135:96] != 40'd0) begin
          force_next = FORCE_MAX;
          saturated_next = 1'b1;
        end else begin
          force_next = t_lin6[95:48];
        end
      end
      REGION_EXP: begin
        if (a6 != 112'd0) begin
          if (exp_big || t_exp[127:118] != 10'd0) begin
            force_next = FORCE_MAX;
            saturated_next = 1'b1;
          end else begin
            force_next = t_exp[117:70];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      region <= reg6;
      force_res <= force_next;
      saturated <= saturated_next;
    end
  end

endmodule

// File: rtl/collagen_spring_force.sv
// Force of one collagen fibre spring per transfer. Input tdata packs current_length,
// rest_length, stiffness; output tdata packs force_res (Q40.8), region, saturated.
// One item enters per clock unless the output stalls: the 57-bit quotient is formed
// by a chain of 19 divider cells of three bits each, followed by seven force stages
// (strain and region, exponent and coefficient partial products, table read,
// interpolation, wide partial products, their sums, saturation into the output
// register). The whole pipe advances when the output register is free or being drained.
// Registers must be written through the cfg port only while idle; the block does not enforce it.
module collagen_spring_force
  import csf_pkg::*;
#(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,  // current_length, rest_length, stiffness
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata,  // force_res, region, saturated, zero pad
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int unsigned CELLS = 19;

  logic [31:0] exp_scale, linear_modulus;
  logic [23:0] exp_rate;
  logic [15:0] recruit_strain, intercept_strain, tissue_thickness;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_scale <= 32'd304309862;
      exp_rate <= 24'd3274460;
      recruit_strain <= 16'd9503;
      linear_modulus <= 32'd325000000;
      intercept_strain <= 16'd8192;
      tissue_thickness <= 16'd6554;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXP_SCALE: exp_scale <= cfg_data;
        REG_EXP_RATE: exp_rate <= cfg_data[23:0];
        REG_RECRUIT: recruit_strain <= cfg_data[15:0];
        REG_MODULUS: linear_modulus <= cfg_data;
        REG_INTERCEPT: intercept_strain <= cfg_data[15:0];
        REG_THICKNESS: tissue_thickness <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  div_stage_t chain [CELLS+1];

  always_comb begin
    chain[0].valid = s_tvalid;
    chain[0].rem = 57'd0;
    chain[0].num = {1'b0, s_tdata[31:0], 24'd0};
    chain[0].quo = 57'd0;
    chain[0].zero_div = (s_tdata[63:32] == 32'd0);
    chain[0].den = s_tdata[63:32];
    chain[0].stiffness = s_tdata[95:64];
  end

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    csf_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .din (chain[g]),
      .dout(chain[g+1])
    );
  end

  logic [56:0] ratio;
  assign ratio = chain[CELLS].zero_div ? {1'b0, {56{1'b1}}} : chain[CELLS].quo;

  logic        f_valid, saturated;
  logic [47:0] force_res;
  logic [1:0]  region;

  csf_force_pipe #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_force (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(chain[CELLS].valid), .ratio(ratio), .stiffness(chain[CELLS].stiffness),
    .exp_scale(exp_scale), .exp_rate(exp_rate), .recruit_strain(recruit_strain),
    .linear_modulus(linear_modulus), .intercept_strain(intercept_strain),
    .tissue_thickness(tissue_thickness),
    .out_valid(f_valid), .force_res(force_res), .region(region), .saturated(saturated)
  );

  assign m_tvalid = f_valid;
  assign m_tdata = {5'd0, saturated, region, force_res};

endmodule

// File: tb/sv/tb_top.sv
module tb_top
  import csf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [47:0] force_res;
    logic [1:0]  region;
    logic        saturated;
  } force_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [55:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  logic [95:0]  spring_q[$];
  force_t       force_q[$];
  bit           idle_en = 1'b1;
  int           errors = 0;
  int           stuck_cycles = 0;

  logic [31:0] scale_r;
  logic [23:0] rate_r;
  logic [15:0] recruit_r;
  logic [31:0] modulus_r;
  logic [15:0] intercept_r;
  logic [15:0] thick_r;
  logic [31:0] pow2_rom[0:256];

  collagen_spring_force DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int bitlen(input logic [127:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  function automatic force_t spring_force(input logic [31:0] len, input logic [31:0] rest,
                                          input logic [31:0] kappa);
    force_t      res;
    logic [63:0] ratio;
    logic [63:0] strain;
    logic [63:0] c;
    logic [63:0] y;
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] m;
    logic [63:0] lo_v;
    logic [63:0] hi_v;
    logic [127:0] a1;
    logic [127:0] a;
    logic [255:0] t;
    int          n;
    int          idx;
    res = '0;
    ratio = (rest != 0) ? ({32'd0, len} << 24) / {32'd0, rest} : (64'd1 << 56) - 64'd1;
    c = {32'd0, kappa} * {48'd0, thick_r};
    if (ratio > (64'd1 << 24)) begin
      strain = ratio - (64'd1 << 24);
      if (strain > ({48'd0, recruit_r} << 8)) begin
        res.region = REGION_LINEAR;
        if (strain > ({48'd0, intercept_r} << 8)) begin
          t = 256'(c) * 256'(modulus_r) * 256'(strain - ({48'd0, intercept_r} << 8));
          t = t >> 48;
          if (t > 256'(FORCE_MAX)) begin
            res.saturated = 1'b1;
            res.force_res = FORCE_MAX;
          end else begin
            res.force_res = t[47:0];
          end
        end
      end else begin
        res.region = REGION_EXP;
        y = ((({40'd0, rate_r} * strain) >> 16) * 64'(LOG2E_Q30)) >> 30;
        n = int'(y >> 24);
        u = (y & 64'hFF_FFFF) * 64'd256;
        idx = int'(u >> 24);
        r = u & 64'hFF_FFFF;
        lo_v = 64'(pow2_rom[idx]);
        hi_v = 64'(pow2_rom[idx + 1]);
        m = lo_v + (((hi_v - lo_v) * r) >> 24);
        a1 = 128'(c) * 128'(scale_r);
        a = a1 * 128'(m);
        if (a != 0) begin
          if (bitlen(a) + n > 119) begin
            res.saturated = 1'b1;
            res.force_res = FORCE_MAX;
          end else begin
            t = 256'((a << n) - (a1 << 30)) >> 70;
            if (t > 256'(FORCE_MAX)) begin
              res.saturated = 1'b1;
              res.force_res = FORCE_MAX;
            end else begin
              res.force_res = t[47:0];
            end
          end
        end
      end
    end
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        force_q.push_back(spring_force(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]));
      if (!s_tvalid || s_tready) begin
        if (spring_q.size() > 0 && !(idle_en && $urandom_range(99) < 17)) begin
          s_tdata <= spring_q.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    force_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (force_q.size() == 0) begin
          $error("result transfer with no expectation: %h", m_tdata);
          errors++;
        end else begin
          exp_r = force_q.pop_front();
          if (m_tdata[47:0] !== exp_r.force_res) begin
            $error("force_res expected %h actual %h", exp_r.force_res, m_tdata[47:0]);
            errors++;
          end
          if (m_tdata[49:48] !== exp_r.region) begin
            $error("region expected %0d actual %0d", exp_r.region, m_tdata[49:48]);
            errors++;
          end
          if (m_tdata[50] !== exp_r.saturated) begin
            $error("saturated expected %0d actual %0d", exp_r.saturated, m_tdata[50]);
            errors++;
          end
        end
      end
      m_tready <= !(idle_en && $urandom_range(99) < 17);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles > 5000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    unique case (idx)
      REG_EXP_SCALE: scale_r = val;
      REG_EXP_RATE:  rate_r = val[23:0];
      REG_RECRUIT:   recruit_r = val[15:0];
      REG_MODULUS:   modulus_r = val;
      REG_INTERCEPT: intercept_r = val[15:0];
      REG_THICKNESS: thick_r = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    wait (spring_q.size() == 0 && !s_tvalid && force_q.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [95:0] pack_spring(input logic [31:0] len, input logic [31:0] rest,
                                              input logic [31:0] kappa);
    return {kappa, rest, len};
  endfunction

  // mostly stretched springs near the interesting strains, some noise
  task automatic add_random(input int count);
    logic [31:0] rest;
    logic [31:0] len;
    logic [63:0] grow;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      rest = $urandom_range(32'h7FFF_FFFF, 1);
      if (pick < 60) begin
        grow = ({32'd0, rest} * $urandom_range(30000)) >> 16;
        len = rest + grow[31:0];
      end else if (pick < 80) begin
        len = $urandom_range(rest);
      end else begin
        rest = $urandom;
        len = $urandom;
      end
      spring_q.push_back(pack_spring(len, rest,
                         ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h3_0000)));
    end
  endtask

  initial begin
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    for (int k = 0; k <= 256; k++) begin
      z = (64'(k) * 64'd1488522236) / 64'd256;
      sum = 64'd1 << 31;
      term = 64'd1 << 31;
      for (int i = 1; i <= 16; i++) begin
        term = ((term * z) >> 31) / 64'(i);
        sum = sum + term;
      end
      pow2_rom[k] = 32'((sum + 64'd1) >> 1);
    end
    scale_r = 32'd304309862;
    rate_r = 24'd3274460;
    recruit_r = 16'd9503;
    modulus_r = 32'd325000000;
    intercept_r = 16'd8192;
    thick_r = 16'd6554;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings
    spring_q.push_back(pack_spring(32'h0100_0000, 32'h0100_0000, 32'h0001_0000));
    spring_q.push_back(pack_spring(32'h0080_0000, 32'h0100_0000, 32'h0001_0000));
    spring_q.push_back(pack_spring(32'h0110_0000, 32'h0100_0000, 32'h0001_0000));
    spring_q.push_back(pack_spring(32'h0120_0000, 32'h0100_0000, 32'h0001_0000));
    spring_q.push_back(pack_spring(32'h0140_0000, 32'h0100_0000, 32'h0001_0000));
    spring_q.push_back(pack_spring(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF));
    spring_q.push_back(pack_spring(32'h0000_0000, 32'h0000_0000, 32'h0001_0000));
    spring_q.push_back(pack_spring(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
    spring_q.push_back(pack_spring(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    spring_q.push_back(pack_spring(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000));
    spring_q.push_back(pack_spring(32'h0300_0000, 32'h0100_0000, 32'h0000_0000));
    spring_q.push_back(pack_spring(32'h0124_0000, 32'h0100_0000, 32'hFFFF_FFFF));
    add_random(150);
    drain();

    // no idling at all for one stretch
    idle_en = 1'b0;
    add_random(120);
    drain();
    idle_en = 1'b1;

    // recruit below intercept, extremes
    write_reg(REG_RECRUIT, 32'd0);
    write_reg(REG_INTERCEPT, 32'hFFFF);
    write_reg(REG_EXP_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_EXP_RATE, 32'hFF_FFFF);
    write_reg(REG_MODULUS, 32'hFFFF_FFFF);
    write_reg(REG_THICKNESS, 32'hFFFF);
    write_reg(3'd6, 32'h1234_5678);
    write_reg(3'd7, 32'hFFFF_FFFF);
    spring_q.push_back(pack_spring(32'h0101_0000, 32'h0100_0000, 32'h0001_0000));
    spring_q.push_back(pack_spring(32'h0200_0000, 32'h0100_0000, 32'h0000_0001));
    add_random(100);
    drain();

    write_reg(REG_RECRUIT, 32'hFFFF);
    write_reg(REG_INTERCEPT, 32'd0);
    write_reg(REG_EXP_SCALE, 32'd0);
    write_reg(REG_EXP_RATE, 32'd0);
    write_reg(REG_MODULUS, 32'd0);
    write_reg(REG_THICKNESS, 32'd0);
    add_random(60);
    drain();

    write_reg(REG_THICKNESS, 32'hFFFF);
    write_reg(REG_EXP_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_EXP_RATE, 32'hFF_FFFF);
    add_random(80);
    drain();

    for (int p = 0; p < 3; p++) begin
      write_reg(REG_EXP_SCALE, $urandom);
      write_reg(REG_EXP_RATE, $urandom_range(24'hFF_FFFF));
      write_reg(REG_RECRUIT, $urandom_range(16'hFFFF));
      write_reg(REG_MODULUS, $urandom);
      write_reg(REG_INTERCEPT, $urandom_range(16'hFFFF));
      write_reg(REG_THICKNESS, $urandom_range(16'hFFFF));
      add_random(70);
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && force_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
